### rtl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Shared widths, codes and controller/datapath command types for the
// nearest target search block.
// ----------------------------------------------------------------------------
package nts_pkg;

  localparam int POOL_SIZE = 64;
  localparam int AW        = 6;   // slot index bits
  localparam int CFG_W     = 11;
  localparam int POS_W     = 16;
  localparam int DIFF_W    = 18;
  localparam int SQ_W      = 32;
  localparam int SUM_W     = 33;
  localparam int Q_W       = 15;
  localparam int BIT_W     = 4;
  localparam int PROD_W    = 65;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd1280;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd720;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [BIT_W-1:0] TOP_BIT = 4'd14;

  typedef struct packed {
    logic             wr;
    logic             qstart;
    logic             issue;
    logic [AW-1:0]    addr;
    logic             mul_h;
    logic             mul_s;
    logic             cmp;
    logic [BIT_W-1:0] bit_idx;
    logic             load_out;
  } nts_cmd_t;

  typedef struct packed {
    logic out_free;
  } nts_sts_t;

endpackage

### rtl/nts_ctrl.sv
// ----------------------------------------------------------------------------
// nts_ctrl
// Sequencer: slot writes, the slot scan, pipeline drain, the bit-by-bit
// normalisation loop and the hand-over to the output register.
// ----------------------------------------------------------------------------
module nts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  output logic              in_stall_o,
  input  nts_pkg::nts_sts_t sts_i,
  output nts_pkg::nts_cmd_t cmd_o
);
  import nts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_MULH, S_MULS, S_CMP, S_DONE
  } state_e;

  state_e           state_q;
  logic [AW-1:0]    cnt_q;
  logic [BIT_W-1:0] bit_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr     = cnt_q;
    cmd_o.bit_idx  = bit_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.wr     = in_valid_i && (action_i == ACT_WRITE);
        cmd_o.qstart = in_valid_i && (action_i == ACT_QUERY);
      end
      S_SCAN:  cmd_o.issue    = 1'b1;
      S_MULH:  cmd_o.mul_h    = 1'b1;
      S_MULS:  cmd_o.mul_s    = 1'b1;
      S_CMP:   cmd_o.cmp      = 1'b1;
      S_DONE:  cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && (action_i == ACT_QUERY)) begin
            state_q <= S_SCAN;
            cnt_q   <= '0;
          end
        end
        S_SCAN: begin
          if (cnt_q == AW'(POOL_SIZE - 1)) begin
            state_q <= S_DRAIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          // three stages behind the last read
          if (cnt_q == AW'(2)) begin
            state_q <= S_MULH;
            bit_q   <= TOP_BIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MULH: state_q <= S_MULS;
        S_MULS: state_q <= S_CMP;
        S_CMP: begin
          if (bit_q == '0) begin
            state_q <= S_DONE;
          end else begin
            bit_q   <= bit_q - 1'b1;
            state_q <= S_MULH;
          end
        end
        S_DONE: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/nts_dp.sv
// ----------------------------------------------------------------------------
// nts_dp
// Datapath: window registers, slot store, four-stage distance pipeline with
// running best, two-lane square-root-free normaliser and output register.
// ----------------------------------------------------------------------------
module nts_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [nts_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [5:0]                  slot_i,
  input  logic                        slot_active_i,
  input  logic signed [15:0]          pos_x_i,
  input  logic signed [15:0]          pos_y_i,
  input  nts_pkg::nts_cmd_t           cmd_i,
  output nts_pkg::nts_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic signed [15:0]          target_x_o,
  output logic signed [15:0]          target_y_o,
  output logic signed [15:0]          dir_x_o,
  output logic signed [15:0]          dir_y_o
);
  import nts_pkg::*;

  logic [CFG_W-1:0] w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WIDTH_RST;
      h_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  w_q <= cfg_data_i;
        CFG_HEIGHT: h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // slot store: positions in a memory, active marks in flops
  logic [2*POS_W-1:0] mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] act_q;
  logic [2*POS_W-1:0] rd_q;
  logic               ract_q;
  logic               v1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) mem[slot_i[AW-1:0]] <= {pos_x_i, pos_y_i};
    if (cmd_i.issue) begin
      rd_q   <= mem[cmd_i.addr];
      ract_q <= act_q[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (cmd_i.wr) act_q[slot_i[AW-1:0]] <= slot_active_i;
      v1_q <= cmd_i.issue;
    end
  end

  // stage 1: window test and differences
  logic signed [POS_W-1:0]  qx_q, qy_q;
  logic signed [POS_W-1:0]  x1, y1;
  logic signed [POS_W:0]    xmax, ymax;
  logic signed [DIFF_W-1:0] ex1, ey1;
  logic                     inwin;

  assign x1    = rd_q[2*POS_W-1:POS_W];
  assign y1    = rd_q[POS_W-1:0];
  assign xmax  = $signed({2'b00, w_q, 4'b0000});
  assign ymax  = $signed({2'b00, h_q, 4'b0000});
  assign inwin = ract_q
              && ($signed({x1[POS_W-1], x1}) > 0) && ($signed({x1[POS_W-1], x1}) < xmax)
              && ($signed({y1[POS_W-1], y1}) > 0) && ($signed({y1[POS_W-1], y1}) < ymax);
  assign ex1   = $signed({{2{x1[POS_W-1]}}, x1}) - $signed({{2{qx_q[POS_W-1]}}, qx_q});
  assign ey1   = $signed({{2{y1[POS_W-1]}}, y1}) - $signed({{2{qy_q[POS_W-1]}}, qy_q});

  logic                     v2_q, v3_q;
  logic signed [DIFF_W-1:0] ex2_q, ey2_q, ex3_q, ey3_q;
  logic signed [POS_W-1:0]  x2_q, y2_q, x3_q, y3_q;
  logic [SQ_W-1:0]          sqx3_q, sqy3_q;
  logic signed [2*DIFF_W-1:0] prx, pry;

  assign prx = ex2_q * ex2_q;
  assign pry = ey2_q * ey2_q;

  always_ff @(posedge clk_i) begin
    ex2_q  <= ex1;
    ey2_q  <= ey1;
    x2_q   <= x1;
    y2_q   <= y1;
    ex3_q  <= ex2_q;
    ey3_q  <= ey2_q;
    x3_q   <= x2_q;
    y3_q   <= y2_q;
    sqx3_q <= prx[SQ_W-1:0];
    sqy3_q <= pry[SQ_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= v1_q && inwin;
      v3_q <= v2_q;
    end
  end

  // stage 3: running best, first strict improvement wins
  logic [SUM_W-1:0]         s3, best_q, bs_q;
  logic                     fnd_q;
  logic signed [POS_W-1:0]  tx_q, ty_q;
  logic                     negx_q, negy_q;
  logic [SQ_W-1:0]          bsq_q [2];
  logic [POS_W-2:0]         wp;
  logic [2*POS_W-3:0]       wsq;

  assign s3  = SUM_W'(sqx3_q) + SUM_W'(sqy3_q);
  assign wp  = {w_q, 4'b0000};
  assign wsq = wp * wp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.qstart) begin
      qx_q   <= pos_x_i;
      qy_q   <= pos_y_i;
      best_q <= SUM_W'(wsq);
      fnd_q  <= 1'b0;
      tx_q   <= '0;
      ty_q   <= '0;
      bs_q   <= '0;
    end else if (v3_q && (s3 < best_q)) begin
      best_q   <= s3;
      fnd_q    <= 1'b1;
      tx_q     <= x3_q;
      ty_q     <= y3_q;
      bs_q     <= s3;
      negx_q   <= ex3_q[DIFF_W-1];
      negy_q   <= ey3_q[DIFF_W-1];
      bsq_q[0] <= sqx3_q;
      bsq_q[1] <= sqy3_q;
    end
  end

  // normaliser: per bit, keep t when (2t-1)^2 * S <= a^2 << 30
  logic [Q_W-1:0]    q_q   [2];
  logic [SQ_W-1:0]   h2_q  [2];
  logic [48:0]       plo_q [2];
  logic [47:0]       phi_q [2];
  logic [Q_W-1:0]    t_l   [2];
  logic [POS_W-1:0]  h_l   [2];
  logic [PROD_W-1:0] full_l[2];
  logic [PROD_W-1:0] rhs_l [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      t_l[l]    = q_q[l] | (Q_W'(1) << cmd_i.bit_idx);
      h_l[l]    = {t_l[l], 1'b0} - 1'b1;
      full_l[l] = PROD_W'(plo_q[l]) + (PROD_W'(phi_q[l]) << 17);
      rhs_l[l]  = PROD_W'(bsq_q[l]) << 30;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.qstart) q_q[l] <= '0;
      else if (cmd_i.cmp && (full_l[l] <= rhs_l[l])) q_q[l] <= t_l[l];
      if (cmd_i.mul_h) h2_q[l] <= h_l[l] * h_l[l];
      if (cmd_i.mul_s) begin
        plo_q[l] <= h2_q[l] * bs_q[16:0];
        phi_q[l] <= h2_q[l] * bs_q[32:17];
      end
    end
  end

  // output register
  logic                    ov_q;
  logic                    dir_ok;
  logic signed [POS_W-1:0] ux, uy;

  assign dir_ok = fnd_q && (bs_q != '0);
  assign ux = negx_q ? -$signed({1'b0, q_q[0]}) : $signed({1'b0, q_q[0]});
  assign uy = negy_q ? -$signed({1'b0, q_q[1]}) : $signed({1'b0, q_q[1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      found_o    <= fnd_q;
      target_x_o <= tx_q;
      target_y_o <= ty_q;
      dir_x_o    <= dir_ok ? ux : '0;
      dir_y_o    <= dir_ok ? uy : '0;
    end
  end

  assign out_valid_o    = ov_q;
  assign sts_o.out_free = !ov_q || !out_stall_i;

endmodule

### rtl/nearest_target_search.sv
// ----------------------------------------------------------------------------
// nearest_target_search
// Nearest in-window target lookup over a 64-slot table, with unit vector.
// ----------------------------------------------------------------------------
// A write beat (action 0) loads one slot. A query beat (action 1) scans
// the 64 slots (one memory read a cycle), drains the distance pipeline,
// runs the normaliser (15 result bits, three steps each through its
// multipliers) and loads the output register once it is free. The input
// stalls for the whole query; a finished result may wait in the output
// register while the next beat is taken.
// Window registers: index 0 width, index 1 height, in whole pixels.
module nearest_target_search (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [nts_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [5:0]                slot_i,
  input  logic                      slot_active_i,
  input  logic signed [15:0]        pos_x_i,
  input  logic signed [15:0]        pos_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      found_o,
  output logic signed [15:0]        target_x_o,
  output logic signed [15:0]        target_y_o,
  output logic signed [15:0]        dir_x_o,
  output logic signed [15:0]        dir_y_o
);
  import nts_pkg::*;

  nts_cmd_t cmd;
  nts_sts_t sts;

  nts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nts_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .slot_i        (slot_i),
    .slot_active_i (slot_active_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .target_x_o    (target_x_o),
    .target_y_o    (target_y_o),
    .dir_x_o       (dir_x_o),
    .dir_y_o       (dir_y_o)
  );

endmodule
